>>> design/tacs_pkg.sv
// Shared types and constants of the tiny accumulator CPU step block.
`default_nettype none
package tacs_pkg;

    localparam int DATA_W    = 8;
    localparam int MEM_DEPTH = 256;
    localparam int ADDR_W    = 8;
    localparam int RIDX_W    = 2;
    localparam int NUM_REGS  = 4;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_EXEC  = 2'd2;

    localparam logic [DATA_W-1:0] OP_LOAD  = 8'h01;
    localparam logic [DATA_W-1:0] OP_STORE = 8'h02;
    localparam logic [DATA_W-1:0] OP_ADD   = 8'h03;
    localparam logic [DATA_W-1:0] OP_SUB   = 8'h04;
    localparam logic [DATA_W-1:0] OP_MOV   = 8'h05;
    localparam logic [DATA_W-1:0] OP_CMP   = 8'h06;
    localparam logic [DATA_W-1:0] OP_JMP   = 8'h07;
    localparam logic [DATA_W-1:0] OP_JZ    = 8'h08;
    localparam logic [DATA_W-1:0] OP_JNZ   = 8'h09;
    localparam logic [DATA_W-1:0] OP_HALT  = 8'h0A;

    localparam logic [DATA_W-1:0] PC_STEP = 8'd3;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_EXEC,
        KIND_NONE
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_EXECUTE,
        ST_LD_WAIT
    } state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_byte;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_byte;
        logic [DATA_W-1:0] opcode;
        logic [DATA_W-1:0] operand_first;
        logic [DATA_W-1:0] operand_second;
        logic [DATA_W-1:0] reg_zero;
        logic [DATA_W-1:0] reg_one;
        logic [DATA_W-1:0] reg_two;
        logic [DATA_W-1:0] reg_three;
        logic [ADDR_W-1:0] program_counter;
        logic              zero_flag;
        logic              halted;
    } result_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_byte;
    } entry_t;

endpackage
`default_nettype wire

>>> design/tacs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tacs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end
endmodule
`default_nettype wire

>>> design/tacs_front.sv
// Front end: input transfer, item classification and the item queue.
`default_nettype none
module tacs_front
    import tacs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_ready,
    input  wire item_t  item,
    input  wire logic   clearing,
    output logic        q_valid,
    input  wire logic   q_pop,
    output entry_t      q_data
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               pop;
    entry_t             entry_in;

    always_comb
    begin
        entry_in.address    = item.address;
        entry_in.write_byte = item.write_byte;
        unique case (item.mode)
            MODE_WRITE: entry_in.kind = KIND_WRITE;
            MODE_READ:  entry_in.kind = KIND_READ;
            MODE_EXEC:  entry_in.kind = KIND_EXEC;
            default:    entry_in.kind = KIND_NONE;
        endcase
    end

    assign item_ready = !clearing && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && item_ready;
    assign q_valid    = (count_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_data     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= entry_in;
        end
    end
endmodule
`default_nettype wire

>>> design/tacs_back.sv
// Back end: memory sequencer, instruction execution and result register.
`default_nettype none
module tacs_back
    import tacs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_pop,
    input  wire entry_t q_data,
    output logic        clearing,
    output logic        result_valid,
    input  wire logic   result_ready,
    output result_t     result
);
    state_t                          state_reg, state_next;
    logic [ADDR_W-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [NUM_REGS-1:0][DATA_W-1:0] rf_reg, rf_next;
    logic [ADDR_W-1:0]               pc_reg, pc_next;
    logic                            zf_reg, zf_next;
    logic                            halted_reg, halted_next;
    logic [DATA_W-1:0]               op_reg, op_next;
    logic [DATA_W-1:0]               a_reg, a_next;
    logic [DATA_W-1:0]               b_reg, b_next;
    logic                            out_valid_reg;
    result_t                         out_reg;

    logic                            ram_en, ram_we;
    logic [ADDR_W-1:0]               ram_addr;
    logic [DATA_W-1:0]               ram_wdata, ram_rdata;
    logic                            out_free, emit;
    result_t                         res;
    logic [DATA_W-1:0]               val_a, val_b;
    logic [ADDR_W-1:0]               pc_inc;

    tacs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MEM_DEPTH)
    ) u_mem (
        .clk  (clk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign out_free     = !out_valid_reg || result_ready;
    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pc_inc       = pc_reg + PC_STEP;
    assign val_a        = rf_reg[a_reg[RIDX_W-1:0]];
    assign val_b        = rf_reg[ram_rdata[RIDX_W-1:0]];

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        rf_next      = rf_reg;
        pc_next      = pc_reg;
        zf_next      = zf_reg;
        halted_next  = halted_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = '0;
        ram_wdata    = '0;
        q_pop        = 1'b0;
        emit         = 1'b0;
        res          = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_data.kind)
                        KIND_WRITE:
                        begin
                            if (out_free)
                            begin
                                ram_en    = 1'b1;
                                ram_we    = 1'b1;
                                ram_addr  = q_data.address;
                                ram_wdata = q_data.write_byte;
                                q_pop     = 1'b1;
                                emit      = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = q_data.address;
                            q_pop      = 1'b1;
                            state_next = ST_RD_WAIT;
                        end
                        KIND_EXEC:
                        begin
                            if (halted_reg)
                            begin
                                if (out_free)
                                begin
                                    q_pop = 1'b1;
                                    emit  = 1'b1;
                                end
                            end
                            else
                            begin
                                ram_en     = 1'b1;
                                ram_addr   = pc_reg;
                                q_pop      = 1'b1;
                                state_next = ST_FETCH_A;
                            end
                        end
                        KIND_NONE:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                res.read_byte = ram_rdata;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH_A:
            begin
                op_next    = ram_rdata;
                ram_en     = 1'b1;
                ram_addr   = pc_reg + 8'd1;
                state_next = ST_FETCH_B;
            end
            ST_FETCH_B:
            begin
                a_next     = ram_rdata;
                ram_en     = 1'b1;
                ram_addr   = pc_reg + 8'd2;
                state_next = ST_EXECUTE;
            end
            ST_EXECUTE:
            begin
                b_next             = ram_rdata;
                res.opcode         = op_reg;
                res.operand_first  = a_reg;
                res.operand_second = ram_rdata;
                if (op_reg == OP_LOAD)
                begin
                    ram_en     = 1'b1;
                    ram_addr   = ram_rdata;
                    state_next = ST_LD_WAIT;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    pc_next    = pc_inc;
                    state_next = ST_IDLE;
                    unique case (op_reg)
                        OP_STORE:
                        begin
                            ram_en    = 1'b1;
                            ram_we    = 1'b1;
                            ram_addr  = ram_rdata;
                            ram_wdata = val_a;
                        end
                        OP_ADD:  rf_next[a_reg[RIDX_W-1:0]] = val_a + val_b;
                        OP_SUB:  rf_next[a_reg[RIDX_W-1:0]] = val_a - val_b;
                        OP_MOV:  rf_next[a_reg[RIDX_W-1:0]] = ram_rdata;
                        OP_CMP:  zf_next = (val_a == val_b);
                        OP_JMP:  pc_next = a_reg;
                        OP_JZ:   pc_next = zf_reg ? a_reg : pc_inc;
                        OP_JNZ:  pc_next = zf_reg ? pc_inc : a_reg;
                        OP_HALT: halted_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_LD_WAIT:
            begin
                res.opcode         = op_reg;
                res.operand_first  = a_reg;
                res.operand_second = b_reg;
                if (out_free)
                begin
                    emit                        = 1'b1;
                    rf_next[a_reg[RIDX_W-1:0]]  = ram_rdata;
                    pc_next                     = pc_inc;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.reg_zero        = rf_next[0];
        res.reg_one         = rf_next[1];
        res.reg_two         = rf_next[2];
        res.reg_three       = rf_next[3];
        res.program_counter = pc_next;
        res.zero_flag       = zf_next;
        res.halted          = halted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rf_reg        <= '0;
            pc_reg        <= '0;
            zf_reg        <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rf_reg      <= rf_next;
            pc_reg      <= pc_next;
            zf_reg      <= zf_next;
            halted_reg  <= halted_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        if (emit)
        begin
            out_reg <= res;
        end
    end
endmodule
`default_nettype wire

>>> design/tiny_accumulator_cpu_step.sv
// Top level of the tiny accumulator CPU step block.
// Flow: the back end takes one queued item at a time over the single memory port;
// an execute makes three fetch reads plus, for load and store, the data access.
// Path: with the back end idle, a queued write, halted execute or mode three is
// answered from ST_IDLE, a read via ST_RD_WAIT, an execute via ST_FETCH_A,
// ST_FETCH_B, ST_EXECUTE (and ST_LD_WAIT for load). Reset clears registers, pc
// and flags at once; ST_CLEAR then zeroes the memory while item_ready stays low.
`default_nettype none
module tiny_accumulator_cpu_step
    import tacs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);
    logic   q_valid;
    logic   q_pop;
    entry_t q_data;
    logic   clearing;

    tacs_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data)
    );

    tacs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_data),
        .clearing    (clearing),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );
endmodule
`default_nettype wire

>>> test/cpu_step_checker.sv
// Checker for the tiny accumulator CPU step block: predicts each result and compares it.
`default_nettype none
module cpu_step_checker
    import tacs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_ready,
    input  wire item_t   item,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result,
    output int           mismatches,
    output int           outstanding
);

    logic [DATA_W-1:0] mem_copy [MEM_DEPTH];
    logic [DATA_W-1:0] reg_copy [NUM_REGS];
    logic [ADDR_W-1:0] pc_copy;
    logic              zf_copy;
    logic              running;
    result_t           expected_results [$];
    result_t           want;
    int                i;

    function automatic result_t cpu_step(input item_t it);
        result_t           r;
        logic [DATA_W-1:0] op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [ADDR_W-1:0] at_a;
        logic [ADDR_W-1:0] at_b;
        logic [RIDX_W-1:0] ra;
        logic [RIDX_W-1:0] rb;
        r = '0;
        case (it.mode)
            MODE_WRITE:
                mem_copy[it.address] = it.write_byte;
            MODE_READ:
                r.read_byte = mem_copy[it.address];
            MODE_EXEC:
                if (running)
                begin
                    at_a = pc_copy + 8'd1;
                    at_b = pc_copy + 8'd2;
                    op = mem_copy[pc_copy];
                    a = mem_copy[at_a];
                    b = mem_copy[at_b];
                    pc_copy = pc_copy + PC_STEP;
                    ra = a[RIDX_W-1:0];
                    rb = b[RIDX_W-1:0];
                    case (op)
                        OP_LOAD:  reg_copy[ra] = mem_copy[b];
                        OP_STORE: mem_copy[b] = reg_copy[ra];
                        OP_ADD:   reg_copy[ra] = reg_copy[ra] + reg_copy[rb];
                        OP_SUB:   reg_copy[ra] = reg_copy[ra] - reg_copy[rb];
                        OP_MOV:   reg_copy[ra] = b;
                        OP_CMP:   zf_copy = (reg_copy[ra] == reg_copy[rb]);
                        OP_JMP:   pc_copy = a;
                        OP_JZ:    if (zf_copy) pc_copy = a;
                        OP_JNZ:   if (!zf_copy) pc_copy = a;
                        OP_HALT:  running = 1'b0;
                        default:  ;
                    endcase
                    r.opcode = op;
                    r.operand_first = a;
                    r.operand_second = b;
                end
            default: ;
        endcase
        r.reg_zero = reg_copy[0];
        r.reg_one = reg_copy[1];
        r.reg_two = reg_copy[2];
        r.reg_three = reg_copy[3];
        r.program_counter = pc_copy;
        r.zero_flag = zf_copy;
        r.halted = !running;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < MEM_DEPTH; i++)
                mem_copy[i] = '0;
            for (i = 0; i < NUM_REGS; i++)
                reg_copy[i] = '0;
            pc_copy = '0;
            zf_copy = 1'b0;
            running = 1'b1;
            expected_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result expected none, actual %p", $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_byte", want.read_byte, result.read_byte);
                    check_field("opcode", want.opcode, result.opcode);
                    check_field("operand_first", want.operand_first, result.operand_first);
                    check_field("operand_second", want.operand_second, result.operand_second);
                    check_field("reg_zero", want.reg_zero, result.reg_zero);
                    check_field("reg_one", want.reg_one, result.reg_one);
                    check_field("reg_two", want.reg_two, result.reg_two);
                    check_field("reg_three", want.reg_three, result.reg_three);
                    check_field("program_counter", want.program_counter,
                                result.program_counter);
                    check_field("zero_flag", {7'd0, want.zero_flag}, {7'd0, result.zero_flag});
                    check_field("halted", {7'd0, want.halted}, {7'd0, result.halted});
                end
            end
            if (item_valid && item_ready)
                expected_results.push_back(cpu_step(item));
            outstanding = expected_results.size();
        end
    end

endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench top for the tiny accumulator CPU step block: stimulus, flow control and verdict.
`default_nettype none
module tb;
    import tacs_pkg::*;

    localparam logic [1:0] MODE_NOP     = 2'd3;
    localparam int         ITEM_TARGET  = 1000;
    localparam int         QUIET_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 10;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    item_t             item;
    logic              result_valid;
    logic              result_ready;
    result_t           result;
    int                mismatches;
    int                outstanding;
    int                items_sent = 0;
    int                results_seen = 0;
    int                quiet_cycles = 0;
    int                hold_left = 0;
    int                stall_draw;
    logic [ADDR_W-1:0] last_pc;
    logic              idle_on;

    tiny_accumulator_cpu_step uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    cpu_step_checker step_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // while idle_on is set, hold ready low for a random stall after each transfer
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            results_seen <= results_seen + 1;
            last_pc <= result.program_counter;
            stall_draw = idle_on ? $urandom_range(0, 4) : 0;
            hold_left <= stall_draw;
            result_ready <= (stall_draw == 0);
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= (hold_left == 1);
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [DATA_W-1:0] operand_byte();
        logic [DATA_W-1:0] v;
        v = DATA_W'($urandom);
        return (v == OP_HALT) ? ~v : v;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [ADDR_W-1:0] address,
                             input logic [DATA_W-1:0] write_byte);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{mode: mode, address: address, write_byte: write_byte};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_results();
        if (results_seen != items_sent)
        begin
            item_valid <= 1'b0;
            wait (results_seen == items_sent);
        end
    endtask

    // place one instruction at the current pc, then execute it
    task automatic run_instruction(input logic [DATA_W-1:0] op, input logic [DATA_W-1:0] a,
                                   input logic [DATA_W-1:0] b);
        logic [ADDR_W-1:0] base;
        wait_results();
        base = last_pc;
        send_item(MODE_WRITE, base, op);
        send_item(MODE_WRITE, base + 8'd1, a);
        send_item(MODE_WRITE, base + 8'd2, b);
        send_item(MODE_EXEC, ADDR_W'($urandom), DATA_W'($urandom));
    endtask

    initial
    begin : stimulus
        int                pick;
        logic [DATA_W-1:0] op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        last_pc = '0;
        idle_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_item(MODE_EXEC, 8'h00, 8'h00);
        send_item(MODE_WRITE, 8'hFF, 8'hFF);
        send_item(MODE_READ, 8'hFF, 8'h00);
        send_item(MODE_READ, 8'h00, 8'hFF);
        send_item(MODE_NOP, 8'hAA, 8'h55);
        run_instruction(OP_MOV, 8'hFD, 8'hFF);
        run_instruction(OP_ADD, 8'h01, 8'h05);
        run_instruction(OP_JMP, 8'hFE, 8'h00);
        run_instruction(OP_CMP, 8'h07, 8'h03);
        run_instruction(OP_JZ, 8'h40, 8'h00);

        while (items_sent < ITEM_TARGET - 8)
        begin
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 99) < 85)
                    op = DATA_W'($urandom_range(OP_LOAD, OP_JNZ));
                else
                begin
                    op = DATA_W'($urandom);
                    if (op >= OP_LOAD && op <= OP_HALT)
                        op = op | 8'h10;
                end
                a = operand_byte();
                b = operand_byte();
                if (op == OP_CMP && $urandom_range(0, 2) == 0)
                    b[RIDX_W-1:0] = a[RIDX_W-1:0];
                run_instruction(op, a, b);
            end
            else if (pick < 80)
                send_item(MODE_WRITE, ADDR_W'($urandom), operand_byte());
            else if (pick < 92)
                send_item(MODE_READ, ADDR_W'($urandom), DATA_W'($urandom));
            else if (pick < 96)
                send_item(MODE_EXEC, ADDR_W'($urandom), DATA_W'($urandom));
            else
                send_item(MODE_NOP, ADDR_W'($urandom), DATA_W'($urandom));
        end

        run_instruction(OP_HALT, operand_byte(), operand_byte());
        send_item(MODE_EXEC, 8'h00, 8'h00);
        send_item(MODE_WRITE, 8'h80, 8'h5A);
        send_item(MODE_READ, 8'h80, 8'h00);
        send_item(MODE_EXEC, 8'hFF, 8'hFF);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

>>> tiny_accumulator_cpu_step.f
design/tacs_pkg.sv
design/tacs_ram.sv
design/tacs_front.sv
design/tacs_back.sv
design/tiny_accumulator_cpu_step.sv
test/cpu_step_checker.sv
test/tb.sv
